// File: src/mmpd_pkg.sv
// Shared types and constants of the multi-motor PID position drive.
package mmpd_pkg;

  // Widths of the fixed fields and of the working datapath.
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned LIM_W   = 16;
  localparam int unsigned POS_W   = 24;
  localparam int unsigned ERR_W   = 25;
  localparam int unsigned DERR_W  = 26;
  localparam int unsigned PROD_W  = 51;
  localparam int unsigned SUM_W   = 56;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned OUT_W   = 17;
  localparam int unsigned MOTOR_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Division by ten retires four quotient bits per cycle.
  localparam int unsigned DIV_RADIX_BITS = 4;
  localparam int unsigned DIV_STEPS      = SUM_W / DIV_RADIX_BITS;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS);
  localparam logic [4:0]  DIVISOR        = 5'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_DUTY_LIMIT  = 3'd4,
    REG_LOWEST_DUTY = 3'd5,
    REG_ERROR_TOL   = 3'd6,
    REG_STOP_BAND   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [LIM_W-1:0]  integ_limit;
    logic [LIM_W-1:0]  duty_limit;
    logic [LIM_W-1:0]  lowest_duty;
    logic [LIM_W-1:0]  error_tolerance;
    logic [LIM_W-1:0]  stop_band;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_I,
    ST_ACC,
    ST_DECAY,
    ST_DECAY_WAIT,
    ST_SUM,
    ST_MIX,
    ST_MIX_WAIT,
    ST_WB
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_p;
    logic mul_d;
    logic mul_i;
    logic acc_upd;
    logic decay_start;
    logic decay_take;
    logic sum_acc;
    logic mix_start;
    logic mix_take;
    logic write_back;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic decay;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [SUM_W-1:0] magnitude(logic signed [SUM_W-1:0] x);
    return x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
  endfunction

  function automatic logic signed [SUM_W-1:0] apply_sign(logic [SUM_W-1:0] m, logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

// File: src/mmpd_div10.sv
// Sequential unsigned divider by ten, four quotient bits per cycle.
module mmpd_div10 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mmpd_pkg::SUM_W-1:0]   dividend_i,
  output logic                         done_o,
  output logic [mmpd_pkg::SUM_W-1:0]   quotient_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [mmpd_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [3:0]                          rem_q, rem_d;
  logic [mmpd_pkg::SUM_W-1:0]          sh_q, sh_d;

  always_comb begin
    logic [4:0]                 trial;
    logic [3:0]                 r;
    logic [mmpd_pkg::SUM_W-1:0] sh;
    r     = rem_q;
    sh    = sh_q;
    trial = '0;
    // Quotient bits enter at the bottom as dividend bits leave at the top.
    for (int i = 0; i < int'(mmpd_pkg::DIV_RADIX_BITS); i++) begin
      trial = {r, sh[mmpd_pkg::SUM_W-1]};
      sh    = sh << 1;
      if (trial >= mmpd_pkg::DIVISOR) begin
        r     = 4'(trial - mmpd_pkg::DIVISOR);
        sh[0] = 1'b1;
      end else begin
        r = trial[3:0];
      end
    end
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      sh_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = r;
      sh_d  = sh;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mmpd_pkg::DIV_CNT_W'(mmpd_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

// File: src/mmpd_ctrl.sv
// Sequencer that steps one sample through the shared multiplier and divider.
module mmpd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mmpd_pkg::dp_status_t status_i,
  output mmpd_pkg::dp_cmd_t    cmd_o
);

  mmpd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmpd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mmpd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mmpd_pkg::ST_MUL_P;
        end
      end
      mmpd_pkg::ST_MUL_P: begin
        if (status_i.in_range) begin
          cmd_o.mul_p = 1'b1;
          state_d     = mmpd_pkg::ST_MUL_D;
        end else begin
          state_d = mmpd_pkg::ST_WB;
        end
      end
      mmpd_pkg::ST_MUL_D: begin
        cmd_o.mul_d = 1'b1;
        state_d     = mmpd_pkg::ST_MUL_I;
      end
      mmpd_pkg::ST_MUL_I: begin
        cmd_o.mul_i = 1'b1;
        state_d     = mmpd_pkg::ST_ACC;
      end
      mmpd_pkg::ST_ACC: begin
        cmd_o.acc_upd = 1'b1;
        state_d       = status_i.decay ? mmpd_pkg::ST_DECAY : mmpd_pkg::ST_SUM;
      end
      mmpd_pkg::ST_DECAY: begin
        cmd_o.decay_start = 1'b1;
        state_d           = mmpd_pkg::ST_DECAY_WAIT;
      end
      mmpd_pkg::ST_DECAY_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.decay_take = 1'b1;
          state_d          = mmpd_pkg::ST_SUM;
        end
      end
      mmpd_pkg::ST_SUM: begin
        cmd_o.sum_acc = 1'b1;
        state_d       = mmpd_pkg::ST_MIX;
      end
      mmpd_pkg::ST_MIX: begin
        cmd_o.mix_start = 1'b1;
        state_d         = mmpd_pkg::ST_MIX_WAIT;
      end
      mmpd_pkg::ST_MIX_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.mix_take = 1'b1;
          state_d        = mmpd_pkg::ST_WB;
        end
      end
      mmpd_pkg::ST_WB: begin
        if (status_i.out_free) begin
          cmd_o.write_back = 1'b1;
          state_d          = mmpd_pkg::ST_IDLE;
        end
      end
      default: state_d = mmpd_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: src/mmpd_datapath.sv
// Datapath: per-motor state, shared multiplier, divide-by-ten and output register.
module mmpd_datapath #(
  parameter int unsigned MOTOR_COUNT   = 8,
  parameter int unsigned STALL_SAMPLES = 10,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mmpd_pkg::cfg_t                       cfg_i,
  input  mmpd_pkg::dp_cmd_t                    cmd_i,
  output mmpd_pkg::dp_status_t                 status_o,
  input  logic [mmpd_pkg::MOTOR_W-1:0]         motor_i,
  input  logic signed [mmpd_pkg::POS_W-1:0]    target_position_i,
  input  logic signed [mmpd_pkg::POS_W-1:0]    measured_position_i,
  input  logic                                 enable_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [mmpd_pkg::MOTOR_W-1:0]         motor_out_o,
  output logic                                 forward_o,
  output logic [mmpd_pkg::DUTY_W-1:0]          duty_o,
  output logic                                 brake_o,
  output logic                                 stall_boost_o
);

  localparam int unsigned IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int unsigned ACC_W = mmpd_pkg::LIM_W + 1 + FRACTION_BITS;
  localparam int unsigned CNT_W = $clog2(STALL_SAMPLES + 1);
  localparam int unsigned SW    = mmpd_pkg::SUM_W;

  // Per-motor state.
  logic signed [ACC_W-1:0]                 acc_mem_q   [MOTOR_COUNT];
  logic signed [mmpd_pkg::ERR_W-1:0]       perr_mem_q  [MOTOR_COUNT];
  logic signed [mmpd_pkg::OUT_W-1:0]       pout_mem_q  [MOTOR_COUNT];
  logic signed [mmpd_pkg::POS_W-1:0]       ppos_mem_q  [MOTOR_COUNT];
  logic [CNT_W-1:0]                        stall_mem_q [MOTOR_COUNT];

  // Working registers of the sample in flight.
  logic [mmpd_pkg::MOTOR_W-1:0]            motor_q;
  logic [IDX_W-1:0]                        idx_q;
  logic                                    in_range_q;
  logic                                    en_q;
  logic signed [mmpd_pkg::POS_W-1:0]       meas_q;
  logic signed [mmpd_pkg::ERR_W-1:0]       e_q;
  logic signed [mmpd_pkg::DERR_W-1:0]      de_q;
  logic                                    decay_q;
  logic signed [mmpd_pkg::PROD_W-1:0]      prod_q;
  logic signed [SW-1:0]                    sum_q;
  logic signed [SW-1:0]                    acc_q;
  logic                                    div_neg_q;
  logic [SW-1:0]                           o_mag_q;
  logic                                    o_neg_q;

  // Output register.
  logic                                    out_valid_q;
  logic [mmpd_pkg::MOTOR_W-1:0]            motor_out_q;
  logic                                    forward_q;
  logic [mmpd_pkg::DUTY_W-1:0]             duty_q;
  logic                                    brake_q;
  logic                                    boost_q;

  // Shared multiplier operands.
  logic [mmpd_pkg::GAIN_W-1:0]             mul_a;
  logic signed [mmpd_pkg::DERR_W-1:0]      mul_b;
  logic signed [mmpd_pkg::PROD_W-1:0]      mul_p;

  logic signed [mmpd_pkg::ERR_W-1:0]       e_new;
  logic [mmpd_pkg::ERR_W-1:0]              e_mag;
  logic [19:0]                             decay_band;
  logic signed [SW-1:0]                    prod_ext;
  logic signed [SW-1:0]                    acc_raw;
  logic [SW-1:0]                           acc_raw_mag;
  logic [SW-1:0]                           ilim_sc;
  logic [SW-1:0]                           dlim_sc;
  logic [SW-1:0]                           acc_mag;
  logic signed [SW-1:0]                    prev_sc;
  logic signed [SW-1:0]                    mix_num;
  logic                                    div_start;
  logic [SW-1:0]                           div_in;
  logic                                    div_done;
  logic [SW-1:0]                           div_q;

  logic [mmpd_pkg::DUTY_W-1:0]             oi_mag;
  logic [mmpd_pkg::DUTY_W-1:0]             duty_base;
  logic                                    stall_hit;
  logic [CNT_W-1:0]                        cnt_inc;
  logic                                    boost;
  logic                                    brake;
  logic [25:0]                             brake_band;

  assign e_new = $signed({target_position_i[mmpd_pkg::POS_W-1], target_position_i})
               - $signed({measured_position_i[mmpd_pkg::POS_W-1], measured_position_i});
  assign e_mag = e_q[mmpd_pkg::ERR_W-1] ? mmpd_pkg::ERR_W'(-e_q) : mmpd_pkg::ERR_W'(e_q);
  assign decay_band = (20'(cfg_i.stop_band) << 3) + (20'(cfg_i.stop_band) << 1);

  always_comb begin
    priority if (cmd_i.mul_p) begin
      mul_a = cfg_i.prop_gain;
      mul_b = mmpd_pkg::DERR_W'(e_q);
    end else if (cmd_i.mul_d) begin
      mul_a = cfg_i.deriv_gain;
      mul_b = de_q;
    end else begin
      mul_a = cfg_i.integ_gain;
      mul_b = mmpd_pkg::DERR_W'(e_q);
    end
  end
  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  assign prod_ext    = SW'(prod_q);
  assign acc_raw     = SW'(acc_mem_q[idx_q]) + prod_ext;
  assign acc_raw_mag = mmpd_pkg::magnitude(acc_raw);
  assign ilim_sc     = SW'(cfg_i.integ_limit) << FRACTION_BITS;
  assign dlim_sc     = SW'(cfg_i.duty_limit) << FRACTION_BITS;
  assign acc_mag     = mmpd_pkg::magnitude(acc_q);
  assign prev_sc     = SW'(pout_mem_q[idx_q]) <<< FRACTION_BITS;
  assign mix_num     = (sum_q <<< 3) - sum_q + (prev_sc <<< 1) + prev_sc;

  assign div_start = cmd_i.decay_start | cmd_i.mix_start;
  assign div_in    = cmd_i.decay_start ? (acc_mag << 3) + acc_mag
                                       : mmpd_pkg::magnitude(mix_num);

  mmpd_div10 u_div10 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_in),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Result formation at write-back.
  assign oi_mag    = mmpd_pkg::DUTY_W'(o_mag_q >> FRACTION_BITS);
  assign duty_base = (oi_mag < cfg_i.lowest_duty) ? cfg_i.lowest_duty : oi_mag;
  assign stall_hit = (e_mag > mmpd_pkg::ERR_W'(cfg_i.error_tolerance))
                  && (meas_q == ppos_mem_q[idx_q]);
  assign cnt_inc   = stall_mem_q[idx_q] + 1'b1;
  assign boost     = stall_hit && (cnt_inc >= CNT_W'(STALL_SAMPLES));
  assign brake_band = (26'(cfg_i.stop_band) << 2) + 26'(cfg_i.stop_band);
  assign brake     = !en_q && ($signed({{2{meas_q[mmpd_pkg::POS_W-1]}}, meas_q})
                               <= $signed(brake_band));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      motor_q <= motor_i;
      idx_q   <= IDX_W'(motor_i);
      en_q    <= enable_i;
      meas_q  <= measured_position_i;
      e_q     <= e_new;
    end
    if (cmd_i.mul_p) begin
      de_q    <= $signed({e_q[mmpd_pkg::ERR_W-1], e_q})
               - $signed({perr_mem_q[idx_q][mmpd_pkg::ERR_W-1], perr_mem_q[idx_q]});
      decay_q <= (e_mag <= mmpd_pkg::ERR_W'(decay_band));
    end
    if (cmd_i.mul_p || cmd_i.mul_d || cmd_i.mul_i) begin
      prod_q <= mul_p;
    end
    if (cmd_i.mul_d) begin
      sum_q <= prod_ext;
    end else if (cmd_i.mul_i) begin
      sum_q <= sum_q + prod_ext;
    end else if (cmd_i.sum_acc) begin
      sum_q <= sum_q + acc_q;
    end
    if (cmd_i.acc_upd) begin
      acc_q <= mmpd_pkg::apply_sign((acc_raw_mag > ilim_sc) ? ilim_sc : acc_raw_mag,
                                    acc_raw[SW-1]);
    end else if (cmd_i.decay_take) begin
      acc_q <= mmpd_pkg::apply_sign(div_q, div_neg_q);
    end
    if (cmd_i.decay_start) begin
      div_neg_q <= acc_q[SW-1];
    end else if (cmd_i.mix_start) begin
      div_neg_q <= mix_num[SW-1];
    end
    if (cmd_i.mix_take) begin
      o_mag_q <= (div_q > dlim_sc) ? dlim_sc : div_q;
      o_neg_q <= div_neg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_range_q <= 1'b0;
      for (int i = 0; i < int'(MOTOR_COUNT); i++) begin
        acc_mem_q[i]   <= '0;
        perr_mem_q[i]  <= '0;
        pout_mem_q[i]  <= '0;
        ppos_mem_q[i]  <= '0;
        stall_mem_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        in_range_q <= (7'(motor_i) < 7'(MOTOR_COUNT));
      end
      if (cmd_i.write_back && in_range_q) begin
        acc_mem_q[idx_q]   <= ACC_W'(acc_q);
        perr_mem_q[idx_q]  <= e_q;
        pout_mem_q[idx_q]  <= o_neg_q ? -$signed({1'b0, oi_mag}) : $signed({1'b0, oi_mag});
        ppos_mem_q[idx_q]  <= meas_q;
        if (stall_hit) begin
          stall_mem_q[idx_q] <= boost ? '0 : cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write_back) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_back) begin
      motor_out_q <= motor_q;
      if (!in_range_q || brake) begin
        forward_q <= 1'b0;
        duty_q    <= '0;
        boost_q   <= 1'b0;
      end else begin
        forward_q <= !o_neg_q && (o_mag_q != '0);
        duty_q    <= boost ? cfg_i.duty_limit : duty_base;
        boost_q   <= boost;
      end
      brake_q <= in_range_q && brake;
    end
  end

  assign status_o.in_range = in_range_q;
  assign status_o.decay    = decay_q;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign motor_out_o   = motor_out_q;
  assign forward_o     = forward_q;
  assign duty_o        = duty_q;
  assign brake_o       = brake_q;
  assign stall_boost_o = boost_q;

endmodule

// File: src/multi_motor_pid_position_drive.sv
// Top level of the multi-motor PID position drive with its configuration registers.
//
// Each accepted transfer carries one position sample for one motor; the block runs a PID
// position loop for that motor in Q-format fixed point (FRACTION_BITS fraction bits),
// with a symmetric integrator clamp, a decay of the integrator to nine tenths inside ten
// stop bands, a 0.7/0.3 blend with the previous output, a duty clamp, a minimum duty,
// a stall boost after STALL_SAMPLES stalled samples and a brake for an idle motor. One
// sample is handled at a time: the shared 25 x 26 bit multiplier forms three products,
// one per cycle, and the divide-by-ten unit, which retires four quotient bits per cycle
// over a 56 bit word, runs once for a sample in range and twice when the integrator
// decay applies. The result waits in an output register, so a new sample is taken
// while the previous result is still unclaimed; the result write itself waits for
// that register to be free. Configuration writes are taken in every cycle and should
// only be issued while the block is idle. A motor index at or above MOTOR_COUNT leaves
// all state unchanged and returns a result with every field but the motor index at
// zero.
module multi_motor_pid_position_drive #(
  parameter int unsigned MOTOR_COUNT   = 8,
  parameter int unsigned STALL_SAMPLES = 10,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Sample input channel.
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [mmpd_pkg::MOTOR_W-1:0]          motor_i,
  input  logic signed [mmpd_pkg::POS_W-1:0]     target_position_i,
  input  logic signed [mmpd_pkg::POS_W-1:0]     measured_position_i,
  input  logic                                  enable_i,
  // Drive command output channel.
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mmpd_pkg::MOTOR_W-1:0]          motor_out_o,
  output logic                                  forward_o,
  output logic [mmpd_pkg::DUTY_W-1:0]           duty_o,
  output logic                                  brake_o,
  output logic                                  stall_boost_o,
  // Configuration write channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mmpd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [mmpd_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  mmpd_pkg::cfg_t       cfg_q;
  mmpd_pkg::dp_cmd_t    cmd;
  mmpd_pkg::dp_status_t status;

  // The register file never stalls a write transfer.
  assign cfg_ready_o = 1'b1;

  // Each register keeps only as many low data bits as it is wide.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= '0;
      cfg_q.integ_gain      <= '0;
      cfg_q.deriv_gain      <= '0;
      cfg_q.integ_limit     <= 16'd400;
      cfg_q.duty_limit      <= 16'd8191;
      cfg_q.lowest_duty     <= '0;
      cfg_q.error_tolerance <= 16'd5;
      cfg_q.stop_band       <= 16'd10;
    end else if (cfg_valid_i) begin
      unique case (mmpd_pkg::cfg_idx_e'(cfg_index_i))
        mmpd_pkg::REG_PROP_GAIN:   cfg_q.prop_gain       <= cfg_data_i;
        mmpd_pkg::REG_INTEG_GAIN:  cfg_q.integ_gain      <= cfg_data_i;
        mmpd_pkg::REG_DERIV_GAIN:  cfg_q.deriv_gain      <= cfg_data_i;
        mmpd_pkg::REG_INTEG_LIMIT: cfg_q.integ_limit     <= cfg_data_i[15:0];
        mmpd_pkg::REG_DUTY_LIMIT:  cfg_q.duty_limit      <= cfg_data_i[15:0];
        mmpd_pkg::REG_LOWEST_DUTY: cfg_q.lowest_duty     <= cfg_data_i[15:0];
        mmpd_pkg::REG_ERROR_TOL:   cfg_q.error_tolerance <= cfg_data_i[15:0];
        mmpd_pkg::REG_STOP_BAND:   cfg_q.stop_band       <= cfg_data_i[15:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // Unless waiting, the sequencer issues one step per cycle; the datapath reports on
  // range, decay, divider completion and whether the output register can take a result.
  mmpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mmpd_datapath #(
    .MOTOR_COUNT   (MOTOR_COUNT),
    .STALL_SAMPLES (STALL_SAMPLES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .cmd_i               (cmd),
    .status_o            (status),
    .motor_i             (motor_i),
    .target_position_i   (target_position_i),
    .measured_position_i (measured_position_i),
    .enable_i            (enable_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .motor_out_o         (motor_out_o),
    .forward_o           (forward_o),
    .duty_o              (duty_o),
    .brake_o             (brake_o),
    .stall_boost_o       (stall_boost_o)
  );

endmodule
